>>> rtl/core/coalescing_free_extent_allocator_macros.svh
// assertion macros for the extent allocator
`ifndef COALESCING_FREE_EXTENT_ALLOCATOR_MACROS_SVH
`define COALESCING_FREE_EXTENT_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define CFEA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CFEA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/cfea_pkg.sv
// shared types and constants of the extent allocator
package cfea_pkg;

    localparam int FREE_ENTRIES = 16;
    localparam int IDX_W        = $clog2(FREE_ENTRIES);
    localparam int CNT_W        = $clog2(FREE_ENTRIES + 1);
    localparam int ADDR_W       = 32;
    localparam int LEN_W        = 24;
    localparam int ENTRY_W      = ADDR_W + LEN_W;

    localparam logic [ADDR_W-1:0] RESET_BASE = 32'h0000_0000;
    localparam logic [LEN_W-1:0]  RESET_SIZE = 24'd4096;
    localparam logic [LEN_W-1:0]  LEN_MAX    = '1;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_GROW  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_RANGE   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_RD,
        S_CMP,
        S_END,
        S_SH_CHK,
        S_SH_WR,
        S_DONE
    } t_state;

    // operands presented to the shared compare/add unit
    typedef struct packed {
        logic [ADDR_W-1:0] e_start;
        logic [LEN_W-1:0]  e_len;
        logic [ADDR_W-1:0] blk_addr;
        logic [LEN_W-1:0]  blk_len;
        logic [LEN_W-1:0]  req;
        logic [LEN_W-1:0]  best_len;
        logic              found;
    } t_unit_in;

    typedef struct packed {
        logic              fits;
        logic              better;
        logic              exact;
        logic              hit_above;
        logic              hit_below;
        logic [LEN_W-1:0]  merged_len;
        logic              grow_ok;
        logic              grow_exact;
        logic [ADDR_W-1:0] grow_start;
        logic [LEN_W-1:0]  grow_rem;
        logic [ADDR_W-1:0] carve_start;
        logic [LEN_W-1:0]  carve_len;
    } t_unit_out;

endpackage

>>> rtl/core/cfea_ram.sv
// generic simple dual-port ram with registered read
module cfea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/cfea_unit.sv
// shared compare and add unit applied to one extent per step
module cfea_unit (
    input  cfea_pkg::t_unit_in  i_op,
    output cfea_pkg::t_unit_out o_res
);
    import cfea_pkg::*;

    logic [ADDR_W:0]  w_end;
    logic [ADDR_W:0]  w_e_end;
    logic [LEN_W:0]   w_sum;
    logic [LEN_W:0]   w_rem;

    assign w_end   = {1'b0, i_op.blk_addr} + {{(ADDR_W-LEN_W+1){1'b0}}, i_op.blk_len};
    assign w_e_end = {1'b0, i_op.e_start} + {{(ADDR_W-LEN_W+1){1'b0}}, i_op.e_len};
    assign w_sum   = {1'b0, i_op.e_len} + {1'b0, i_op.blk_len};
    assign w_rem   = w_sum - {1'b0, i_op.req};

    always_comb begin
        o_res.fits        = i_op.e_len >= i_op.req;
        o_res.better      = !i_op.found || (i_op.e_len < i_op.best_len);
        o_res.exact       = i_op.e_len == i_op.req;
        o_res.hit_above   = {1'b0, i_op.e_start} == w_end;
        o_res.hit_below   = w_e_end == {1'b0, i_op.blk_addr};
        o_res.merged_len  = w_sum[LEN_W] ? LEN_MAX : w_sum[LEN_W-1:0];
        o_res.grow_ok     = w_sum >= {1'b0, i_op.req};
        o_res.grow_exact  = w_sum == {1'b0, i_op.req};
        o_res.grow_start  = i_op.blk_addr + {{(ADDR_W-LEN_W){1'b0}}, i_op.req};
        o_res.grow_rem    = w_rem[LEN_W] ? LEN_MAX : w_rem[LEN_W-1:0];
        o_res.carve_start = i_op.e_start + {{(ADDR_W-LEN_W){1'b0}}, i_op.req};
        o_res.carve_len   = i_op.e_len - i_op.req;
    end

endmodule

>>> rtl/core/coalescing_free_extent_allocator.sv
// top level: extent table sequencer, config registers and result port
//
// Request channel: drive operation and block fields with start high while
// busy is low; the request is taken at that clock edge. Operations are
// allocate (best fit, carved from the front), free (merge with a touching
// extent or append) and grow in place. Exactly one result follows, shown on
// o_status, o_result_address and o_result_length for one cycle with o_done
// high; the receiver cannot stall, so it must sample in that cycle.
// Sequencing: the extent table sits in a ram with registered read and is
// walked one extent at a time through one compare/add unit, each extent
// read (S_RD) and then compared (S_CMP); when an extent is removed, the
// entries above it are moved down one by one (S_SH_CHK, S_SH_WR). busy
// stays high throughout; one request is handled at a time.
// Configuration: APB port, region_base at 0x0, region_size at 0x4; write only
// while idle. Writes change the range check only, never the table.
// Reset: registers return to base 0 and size 4096; after reset, in S_INIT, the
// table is seeded with a single extent covering that region, busy high.
module coalescing_free_extent_allocator (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_operation,
    input  logic [cfea_pkg::ADDR_W-1:0] i_block_address,
    input  logic [cfea_pkg::LEN_W-1:0]  i_block_length,
    input  logic [cfea_pkg::LEN_W-1:0]  i_request_length,
    output logic                     o_done,
    output logic [1:0]               o_status,
    output logic [cfea_pkg::ADDR_W-1:0] o_result_address,
    output logic [cfea_pkg::LEN_W-1:0]  o_result_length
);
    import cfea_pkg::*;

    `include "coalescing_free_extent_allocator_macros.svh"

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    t_status           r_status, n_status;
    logic [ADDR_W-1:0] r_base, r_addr, n_addr, r_res_addr, n_res_addr;
    logic [ADDR_W-1:0] r_best_start, n_best_start;
    logic [LEN_W-1:0]  r_size, r_len, n_len, r_req, n_req;
    logic [LEN_W-1:0]  r_res_len, n_res_len, r_best_len, n_best_len;
    logic [CNT_W-1:0]  r_count, n_count, r_idx, n_idx, r_best_idx, n_best_idx;
    logic              r_found, n_found;

    logic              w_we;
    logic [IDX_W-1:0]  w_waddr, w_raddr;
    logic [ENTRY_W-1:0] w_wdata, w_rdata;
    t_unit_in          w_uin;
    t_unit_out         w_uout;
    logic              w_wr_cfg, w_range_ok, w_chk_finish, w_more, w_stop;
    logic [ADDR_W:0]   w_blk_end, w_reg_end;
    logic [CNT_W:0]    w_idx_inc;

    // configuration port
    assign pready   = 1'b1;
    assign w_wr_cfg = psel && penable && pwrite;
    assign prdata   = paddr[2] ? {{(32-LEN_W){1'b0}}, r_size} : r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= RESET_BASE;
            r_size <= RESET_SIZE;
        end else if (w_wr_cfg) begin
            if (paddr[2]) begin
                r_size <= pwdata[LEN_W-1:0];
            end else begin
                r_base <= pwdata;
            end
        end
    end

    cfea_ram #(.WIDTH(ENTRY_W), .DEPTH(FREE_ENTRIES)) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    cfea_unit u_unit (
        .i_op (w_uin),
        .o_res(w_uout)
    );

    // shared decisions
    assign w_blk_end  = {1'b0, r_addr} + {{(ADDR_W-LEN_W+1){1'b0}}, r_len};
    assign w_reg_end  = {1'b0, r_base} + {{(ADDR_W-LEN_W+1){1'b0}}, r_size};
    assign w_range_ok = (r_addr >= r_base) && (w_blk_end <= w_reg_end);
    assign w_chk_finish = (r_op == OP_NONE)
                       || ((r_op == OP_ALLOC) && (r_req == '0))
                       || ((r_op != OP_ALLOC) && !w_range_ok)
                       || ((r_op == OP_FREE) && (r_len == '0));
    assign w_idx_inc  = {1'b0, r_idx} + {{CNT_W{1'b0}}, 1'b1};
    assign w_more     = w_idx_inc < {1'b0, r_count};
    assign w_stop     = ((r_op == OP_FREE) && (w_uout.hit_above || w_uout.hit_below))
                     || ((r_op == OP_GROW) && w_uout.hit_above && w_uout.grow_ok);

    always_comb begin
        w_uin.blk_addr = r_addr;
        w_uin.blk_len  = r_len;
        w_uin.req      = r_req;
        w_uin.best_len = r_best_len;
        w_uin.found    = r_found;
        if (r_state == S_END) begin
            w_uin.e_start = r_best_start;
            w_uin.e_len   = r_best_len;
        end else begin
            w_uin.e_start = w_rdata[ENTRY_W-1:LEN_W];
            w_uin.e_len   = w_rdata[LEN_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT:  n_state = S_IDLE;
            S_IDLE: begin
                if (start) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_chk_finish)         n_state = S_DONE;
                else if (r_count == '0)   n_state = S_END;
                else                      n_state = S_RD;
            end
            S_RD:    n_state = S_CMP;
            S_CMP: begin
                if (w_stop) begin
                    if ((r_op == OP_GROW) && w_uout.grow_exact) n_state = S_SH_CHK;
                    else                                       n_state = S_DONE;
                end else if (w_more) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_END;
                end
            end
            S_END: begin
                if ((r_op == OP_ALLOC) && r_found && w_uout.exact) n_state = S_SH_CHK;
                else                                                n_state = S_DONE;
            end
            S_SH_CHK: n_state = w_more ? S_SH_WR : S_DONE;
            S_SH_WR:  n_state = S_SH_CHK;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and table control
    always_comb begin
        n_op         = r_op;
        n_addr       = r_addr;
        n_len        = r_len;
        n_req        = r_req;
        n_status     = r_status;
        n_res_addr   = r_res_addr;
        n_res_len    = r_res_len;
        n_count      = r_count;
        n_idx        = r_idx;
        n_best_idx   = r_best_idx;
        n_best_len   = r_best_len;
        n_best_start = r_best_start;
        n_found      = r_found;
        w_we         = 1'b0;
        w_waddr      = r_idx[IDX_W-1:0];
        w_wdata      = '0;
        w_raddr      = r_idx[IDX_W-1:0];
        unique case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = {RESET_BASE, RESET_SIZE};
            end
            S_IDLE: begin
                if (start) begin
                    n_op   = t_op'(i_operation);
                    n_addr = i_block_address;
                    n_len  = i_block_length;
                    n_req  = i_request_length;
                end
            end
            S_CHECK: begin
                n_status   = ST_NOSPACE;
                n_res_addr = '0;
                n_res_len  = '0;
                n_idx      = '0;
                n_found    = 1'b0;
                if ((r_op == OP_FREE) || (r_op == OP_GROW)) begin
                    if (!w_range_ok)         n_status = ST_RANGE;
                    else if ((r_op == OP_FREE) && (r_len == '0)) n_status = ST_OK;
                end
            end
            S_RD: begin
                w_raddr = r_idx[IDX_W-1:0];
            end
            S_CMP: begin
                if ((r_op == OP_ALLOC) && w_uout.fits && w_uout.better) begin
                    n_found      = 1'b1;
                    n_best_idx   = r_idx;
                    n_best_len   = w_uin.e_len;
                    n_best_start = w_uin.e_start;
                end
                if (w_stop) begin
                    n_status = ST_OK;
                    if (r_op == OP_FREE) begin
                        w_we = 1'b1;
                        if (w_uout.hit_above) begin
                            w_wdata = {r_addr, w_uout.merged_len};
                        end else begin
                            w_wdata = {w_uin.e_start, w_uout.merged_len};
                        end
                    end else begin
                        n_res_addr = r_addr;
                        n_res_len  = r_req;
                        if (!w_uout.grow_exact) begin
                            w_we    = 1'b1;
                            w_wdata = {w_uout.grow_start, w_uout.grow_rem};
                        end
                    end
                end else if (w_more) begin
                    n_idx = w_idx_inc[CNT_W-1:0];
                end
            end
            S_END: begin
                if (r_op == OP_ALLOC) begin
                    if (r_found) begin
                        n_status   = ST_OK;
                        n_res_addr = r_best_start;
                        n_res_len  = r_req;
                        if (w_uout.exact) begin
                            n_idx = r_best_idx;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = r_best_idx[IDX_W-1:0];
                            w_wdata = {w_uout.carve_start, w_uout.carve_len};
                        end
                    end
                end else if (r_op == OP_FREE) begin
                    if (r_count < CNT_W'(FREE_ENTRIES)) begin
                        w_we     = 1'b1;
                        w_waddr  = r_count[IDX_W-1:0];
                        w_wdata  = {r_addr, r_len};
                        n_count  = r_count + 1'b1;
                        n_status = ST_OK;
                    end else begin
                        n_status = ST_FULL;
                    end
                end
            end
            S_SH_CHK: begin
                // move the following entry down, or close the table
                if (w_more) begin
                    w_raddr = w_idx_inc[IDX_W-1:0];
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            S_SH_WR: begin
                w_we    = 1'b1;
                w_wdata = w_rdata;
                n_idx   = w_idx_inc[CNT_W-1:0];
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_count <= CNT_W'(1);
            r_op    <= OP_NONE;
            r_found <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_op     <= n_op;
            r_found  <= n_found;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_len        <= n_len;
        r_req        <= n_req;
        r_res_addr   <= n_res_addr;
        r_res_len    <= n_res_len;
        r_idx        <= n_idx;
        r_best_idx   <= n_best_idx;
        r_best_len   <= n_best_len;
        r_best_start <= n_best_start;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = (r_state == S_DONE);
    assign o_status         = r_status;
    assign o_result_address = r_res_addr;
    assign o_result_length  = r_res_len;

    `CFEA_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(FREE_ENTRIES), "extent count overflow")
    `CFEA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request taken but not busy")
    `CFEA_ASSERT_NEXT(a_done_single, o_done, !o_done && !busy, "result not a single strobe")
    `CFEA_ASSERT_NOW(a_fail_zero, o_done && (o_status != ST_OK),
        (o_result_address == '0) && (o_result_length == '0), "failure result not zero")

endmodule
